[rtl/ilbmpb_pkg.sv]
// Shared types and constants for the ILBM PackBits planar row decoder.
package ilbmpb_pkg;

	localparam logic [7:0] HDR_SKIP = 8'h80;
	localparam int unsigned WIDTH_ROUND = 15;
	localparam int unsigned GROUP_ROUND = 7;
	localparam int unsigned GROUP_PIXELS = 8;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_WIDTH  = 2'd0;
	localparam reg_idx_t REG_HEIGHT = 2'd1;
	localparam reg_idx_t REG_PLANES = 2'd2;
	localparam reg_idx_t REG_RLE    = 2'd3;

	localparam logic [9:0]  RST_WIDTH  = 10'd320;
	localparam logic [15:0] RST_HEIGHT = 16'd200;
	localparam logic [3:0]  RST_PLANES = 4'd8;
	localparam logic        RST_RLE    = 1'b1;

	typedef struct packed {
		logic [9:0]  width;
		logic [15:0] height;
		logic [3:0]  planes;
		logic        rle;
	} cfg_t;

	typedef struct packed {
		logic       rst_full;
		logic [7:0] count;
		logic [7:0] data;
	} cmd_t;

endpackage

[rtl/ilbm_packbits_planar_row_decoder.sv]
// Top level of the ILBM PackBits planar row decoder.
// Body bytes enter one per beat on data_byte; the front end decodes ByteRun1 headers and
// queues store commands in a four-entry queue, so it takes one byte per cycle while the
// queue has room. The back end pops one command at a time; header commands write nothing,
// literal and raw bytes write once, and a run of n copies is written one row store write
// per cycle, with copies past the row end dropped at once. When a row fills, it is read
// back from the row store one plane byte per cycle, pausing while a finished group is held
// by an output stall; each eight-pixel group passes through ST_READ, ST_WAIT and ST_OUT,
// and no further commands are taken from the queue until the row is out. Configuration
// registers may only be written while the block is idle; the write port is always ready.
module ilbm_packbits_planar_row_decoder #(
	parameter int MAX_WIDTH = 512,
	parameter int MAX_PLANES = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  ilbmpb_pkg::reg_idx_t cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  logic [7:0]           data_byte,
	output logic                 group_valid,
	input  logic                 group_stall,
	output logic [63:0]          pixel_group,
	output logic [3:0]           valid_pixels,
	output logic                 row_end,
	output logic                 image_end
);
	import ilbmpb_pkg::*;

	cfg_t cfg_q;
	cmd_t push_cmd;
	cmd_t head;
	logic push;
	logic pop;
	logic empty;
	logic full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width <= RST_WIDTH;
			cfg_q.height <= RST_HEIGHT;
			cfg_q.planes <= RST_PLANES;
			cfg_q.rle <= RST_RLE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH:  cfg_q.width <= cfg_data[9:0];
				REG_HEIGHT: cfg_q.height <= cfg_data;
				REG_PLANES: cfg_q.planes <= cfg_data[3:0];
				REG_RLE:    cfg_q.rle <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	ilbmpb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rle        (cfg_q.rle),
		.byte_valid (byte_valid),
		.data_byte  (data_byte),
		.full       (full),
		.byte_stall (byte_stall),
		.push       (push),
		.cmd        (push_cmd)
	);

	ilbmpb_fifo #(
		.DEPTH (4)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	ilbmpb_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_PLANES (MAX_PLANES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.group_stall  (group_stall),
		.group_valid  (group_valid),
		.pixel_group  (pixel_group),
		.valid_pixels (valid_pixels),
		.row_end      (row_end),
		.image_end    (image_end)
	);

endmodule

[rtl/ilbmpb_front.sv]
// Packet front end: accepts body bytes and turns them into store commands.
module ilbmpb_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rle,
	input  logic               byte_valid,
	input  logic [7:0]         data_byte,
	input  logic               full,
	output logic               byte_stall,
	output logic               push,
	output ilbmpb_pkg::cmd_t   cmd
);
	import ilbmpb_pkg::*;

	typedef enum logic [1:0] {PH_HEADER, PH_LITERAL, PH_REPEAT} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] run_q, run_d;

	assign byte_stall = full;
	assign push = byte_valid && !full;

	always_comb begin
		phase_d = phase_q;
		run_d = run_q;
		cmd.rst_full = 1'b0;
		cmd.count = 8'd1;
		cmd.data = data_byte;
		if (!rle) begin
			phase_d = PH_HEADER;
			run_d = '0;
			cmd.rst_full = 1'b1;
		end else begin
			case (phase_q)
				PH_LITERAL: begin
					run_d = run_q - 8'd1;
					if (run_q == 8'd1) begin
						phase_d = PH_HEADER;
					end
				end
				PH_REPEAT: begin
					cmd.count = run_q;
					run_d = '0;
					phase_d = PH_HEADER;
				end
				default: begin
					cmd.rst_full = 1'b1;
					cmd.count = '0;
					if (!data_byte[7]) begin
						phase_d = PH_LITERAL;
						run_d = data_byte + 8'd1;
					end else if (data_byte != HDR_SKIP) begin
						phase_d = PH_REPEAT;
						run_d = 8'(9'd257 - {1'b0, data_byte});
					end else begin
						phase_d = PH_HEADER;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			run_q <= '0;
		end else if (push) begin
			phase_q <= phase_d;
			run_q <= run_d;
		end
	end

endmodule

[rtl/ilbmpb_fifo.sv]
// Short command queue between the packet front end and the row back end.
module ilbmpb_fifo #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ilbmpb_pkg::cmd_t push_data,
	input  logic             pop,
	output ilbmpb_pkg::cmd_t head,
	output logic             empty,
	output logic             full
);
	import ilbmpb_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign empty = (count_q == '0);
	assign full = (count_q == CW'(DEPTH));
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				slot_q[wr_ptr_q] <= push_data;
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[rtl/ilbmpb_back.sv]
// Row back end: fills the row store from commands and emits chunky pixel groups.
module ilbmpb_back #(
	parameter int MAX_WIDTH = 512,
	parameter int MAX_PLANES = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ilbmpb_pkg::cfg_t cfg,
	input  ilbmpb_pkg::cmd_t head,
	input  logic             empty,
	output logic             pop,
	input  logic             group_stall,
	output logic             group_valid,
	output logic [63:0]      pixel_group,
	output logic [3:0]       valid_pixels,
	output logic             row_end,
	output logic             image_end
);
	import ilbmpb_pkg::*;

	localparam int PB_MAX = ((MAX_WIDTH + 15) / 16) * 2;
	localparam int STORE = MAX_PLANES * PB_MAX;
	localparam int AW = $clog2(STORE);
	localparam int FW = $clog2(STORE + 1);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int CW = (WW > 10) ? WW : 10;
	localparam int PSW = $clog2(PB_MAX + 1);
	localparam int GW = $clog2((MAX_WIDTH + 7) / 8 + 1);
	localparam int PCW = $clog2(MAX_PLANES + 1);
	localparam int PLW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

	typedef enum logic [1:0] {ST_EXEC, ST_READ, ST_WAIT, ST_OUT} state_t;

	logic [7:0]     store_mem [STORE];
	logic [7:0]     rd_data_s1;
	logic [PLW-1:0] rd_pl_s1;
	logic           rd_vld_s1;

	state_t         state_q, state_d;
	logic [FW-1:0]  fill_q, fill_d;
	logic           cur_valid_q, cur_valid_d;
	logic [7:0]     cur_cnt_q, cur_cnt_d;
	logic [7:0]     cur_byte_q, cur_byte_d;
	logic [GW-1:0]  grp_q, grp_d;
	logic [PLW-1:0] pl_q, pl_d;
	logic [AW-1:0]  addr_q, addr_d;
	logic [15:0]    row_q, row_d;
	logic [7:0]     planes_q [MAX_PLANES];

	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	logic [7:0]     wr_data;
	logic           load;
	logic           start_emit;

	logic [CW-1:0]  w_ext;
	logic [WW-1:0]  eff_w;
	logic [WW:0]    w_round;
	logic [WW:0]    g_round;
	logic [PSW-1:0] psize;
	logic [PCW-1:0] p_eff;
	logic [FW-1:0]  rl;
	logic [GW-1:0]  groups;
	logic [15:0]    h_eff;
	logic           last_row;
	logic           last_grp;
	logic [FW-1:0]  fe;
	logic [WW:0]    rem;
	logic [3:0]     vp;
	logic [7:0]     pl8 [8];
	logic [63:0]    grp_c;

	always_comb begin
		w_ext = CW'(cfg.width);
		if (w_ext == '0) begin
			eff_w = WW'(1);
		end else if (w_ext > CW'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(w_ext);
		end
		if (cfg.planes == '0) begin
			p_eff = PCW'(1);
		end else if (cfg.planes > 4'(MAX_PLANES)) begin
			p_eff = PCW'(MAX_PLANES);
		end else begin
			p_eff = PCW'(cfg.planes);
		end
		w_round = (WW + 1)'(eff_w) + (WW + 1)'(WIDTH_ROUND);
		psize = PSW'((w_round >> 4) << 1);
		rl = FW'(psize) * FW'(p_eff);
		g_round = (WW + 1)'(eff_w) + (WW + 1)'(GROUP_ROUND);
		groups = GW'(g_round >> 3);
		h_eff = (cfg.height == '0) ? 16'd1 : cfg.height;
		last_row = (17'(row_q) + 17'd1) >= 17'(h_eff);
		last_grp = (grp_q + GW'(1)) == groups;
		rem = (WW + 1)'(eff_w) - ((WW + 1)'(grp_q) << 3);
		vp = (rem >= (WW + 1)'(GROUP_PIXELS)) ? 4'(GROUP_PIXELS) : rem[3:0];
	end

	for (genvar n = 0; n < 8; n++) begin : g_pad
		if (n < MAX_PLANES) begin : g_real
			assign pl8[n] = (PCW'(n) < p_eff) ? planes_q[n] : '0;
		end else begin : g_zero
			assign pl8[n] = '0;
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			for (int n = 0; n < 8; n++) begin
				grp_c[8 * i + n] = pl8[n][7 - i] & (4'(i) < vp);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		fill_d = fill_q;
		cur_valid_d = cur_valid_q;
		cur_cnt_d = cur_cnt_q;
		cur_byte_d = cur_byte_q;
		grp_d = grp_q;
		pl_d = pl_q;
		addr_d = addr_q;
		row_d = row_q;
		pop = 1'b0;
		wr_en = 1'b0;
		wr_addr = AW'(fill_q);
		wr_data = cur_byte_q;
		load = 1'b0;
		start_emit = 1'b0;
		fe = (head.rst_full && fill_q >= rl) ? '0 : fill_q;
		case (state_q)
			ST_EXEC: begin
				if (cur_valid_q) begin
					wr_en = 1'b1;
					fill_d = fill_q + FW'(1);
					cur_cnt_d = cur_cnt_q - 8'd1;
					if (fill_q + FW'(1) == rl) begin
						cur_valid_d = 1'b0;
						start_emit = 1'b1;
					end else if (cur_cnt_q == 8'd1) begin
						cur_valid_d = 1'b0;
					end
				end else if (!empty) begin
					pop = 1'b1;
					fill_d = fe;
					if (head.count != '0 && fe < rl) begin
						wr_en = 1'b1;
						wr_addr = AW'(fe);
						wr_data = head.data;
						fill_d = fe + FW'(1);
						if (fe + FW'(1) == rl) begin
							start_emit = 1'b1;
						end else if (head.count > 8'd1) begin
							cur_valid_d = 1'b1;
							cur_cnt_d = head.count - 8'd1;
							cur_byte_d = head.data;
						end
					end
				end
				if (start_emit) begin
					state_d = ST_READ;
					grp_d = '0;
					pl_d = '0;
					addr_d = '0;
				end
			end
			ST_READ: begin
				addr_d = addr_q + AW'(psize);
				pl_d = pl_q + PLW'(1);
				if (PCW'(pl_q) + PCW'(1) == p_eff) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!group_valid || !group_stall) begin
					load = 1'b1;
					if (last_grp) begin
						row_d = last_row ? '0 : row_q + 16'd1;
						state_d = ST_EXEC;
					end else begin
						grp_d = grp_q + GW'(1);
						addr_d = AW'(grp_q + GW'(1));
						pl_d = '0;
						state_d = ST_READ;
					end
				end
			end
			default: begin
				state_d = ST_EXEC;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= store_mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EXEC;
			fill_q <= '0;
			cur_valid_q <= 1'b0;
			cur_cnt_q <= '0;
			cur_byte_q <= '0;
			grp_q <= '0;
			pl_q <= '0;
			addr_q <= '0;
			row_q <= '0;
			rd_pl_s1 <= '0;
			rd_vld_s1 <= 1'b0;
			group_valid <= 1'b0;
			pixel_group <= '0;
			valid_pixels <= '0;
			row_end <= 1'b0;
			image_end <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q <= fill_d;
			cur_valid_q <= cur_valid_d;
			cur_cnt_q <= cur_cnt_d;
			cur_byte_q <= cur_byte_d;
			grp_q <= grp_d;
			pl_q <= pl_d;
			addr_q <= addr_d;
			row_q <= row_d;
			rd_pl_s1 <= pl_q;
			rd_vld_s1 <= (state_q == ST_READ);
			if (rd_vld_s1) begin
				planes_q[rd_pl_s1] <= rd_data_s1;
			end
			if (load) begin
				group_valid <= 1'b1;
				pixel_group <= grp_c;
				valid_pixels <= vp;
				row_end <= last_grp;
				image_end <= last_grp && last_row;
			end else if (!group_stall) begin
				group_valid <= 1'b0;
			end
		end
	end

endmodule

[rtl/ilbmpb_chk.sv]
// Port checker for the ILBM PackBits planar row decoder, bound to the top level.
module ilbmpb_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input ilbmpb_pkg::reg_idx_t cfg_index,
	input logic [15:0]          cfg_data,
	input logic                 byte_valid,
	input logic                 byte_stall,
	input logic [7:0]           data_byte,
	input logic                 group_valid,
	input logic                 group_stall,
	input logic [63:0]          pixel_group,
	input logic [3:0]           valid_pixels,
	input logic                 row_end,
	input logic                 image_end
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		group_valid && group_stall |=> group_valid && $stable(pixel_group)
			&& $stable(valid_pixels) && $stable(row_end) && $stable(image_end))
		else $error("stalled pixel beat changed");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		group_valid |-> valid_pixels != 4'd0 && valid_pixels <= 4'd8)
		else $error("pixel count out of range");

	a_partial: assert property (@(posedge clk) disable iff (!arst_n)
		group_valid && valid_pixels != 4'd8 |-> row_end)
		else $error("partial group before row end");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		group_valid && valid_pixels < 4'd8 |-> (pixel_group >> (valid_pixels * 8)) == 64'd0)
		else $error("padding pixels not zero");

	a_image: assert property (@(posedge clk) disable iff (!arst_n)
		group_valid && image_end |-> row_end)
		else $error("image end without row end");

endmodule

bind ilbm_packbits_planar_row_decoder ilbmpb_chk u_chk (.*);

[tb/tb_top.sv]
// Self-checking bench for the ILBM PackBits row decoder: directed and random body streams.
`timescale 1ns / 1ps

module tb_top;
	import ilbmpb_pkg::*;

	localparam int MAX_WIDTH = 512;
	localparam int MAX_PLANES = 8;
	localparam int STORE_BYTES = MAX_PLANES * (((MAX_WIDTH + WIDTH_ROUND) / 16) * 2);
	localparam int DRAIN_CYCLES = 1000;
	localparam int RANDOM_BYTES = 340;
	localparam int TIMEOUT_NS = 10_000_000;

	typedef enum logic [1:0] {PK_HEADER, PK_LITERAL, PK_REPEAT} pk_phase_t;

	typedef struct {
		logic [63:0] pixels;
		logic [3:0]  count;
		logic        row_last;
		logic        image_last;
	} pix_group_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	reg_idx_t    cfg_index;
	logic [15:0] cfg_data;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  data_byte;
	logic        group_valid;
	logic        group_stall = 1'b0;
	logic [63:0] pixel_group;
	logic [3:0]  valid_pixels;
	logic        row_end;
	logic        image_end;

	// row predictor state
	cfg_t        model_cfg;
	logic [7:0]  row_mem [STORE_BYTES];
	pk_phase_t   pk;
	logic [7:0]  run_left;
	int unsigned fill_pos;
	logic [15:0] row_number;
	pix_group_t  pending [$];

	bit quiet;
	int mismatches;
	int bytes_sent;
	int used_bytes;
	int groups_checked;
	int rows_emitted;
	int reg_writes;

	ilbm_packbits_planar_row_decoder #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_PLANES(MAX_PLANES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.data_byte(data_byte),
		.group_valid(group_valid),
		.group_stall(group_stall),
		.pixel_group(pixel_group),
		.valid_pixels(valid_pixels),
		.row_end(row_end),
		.image_end(image_end)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("[ilbm_packbits_planar_row_decoder] ERROR");
		$finish;
	end

	function automatic int unsigned eff_width();
		int unsigned w;
		w = model_cfg.width;
		if (w == 0) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned eff_planes();
		int unsigned p;
		p = model_cfg.planes;
		if (p == 0) p = 1;
		if (p > MAX_PLANES) p = MAX_PLANES;
		return p;
	endfunction

	function automatic int unsigned plane_len();
		return ((eff_width() + WIDTH_ROUND) / (WIDTH_ROUND + 1)) * 2;
	endfunction

	function automatic int unsigned row_len();
		return plane_len() * eff_planes();
	endfunction

	function automatic bit store_run(logic [7:0] b, int unsigned cnt, int unsigned rl);
		int unsigned n;
		if (fill_pos >= rl) return 1'b0;
		n = rl - fill_pos;
		if (cnt < n) n = cnt;
		for (int k = 0; k < n; k++) row_mem[fill_pos + k] = b;
		fill_pos += n;
		return fill_pos == rl;
	endfunction

	function automatic void emit_row();
		int unsigned w, p, psz, groups, x, h;
		logic last;
		logic [7:0] pix;
		pix_group_t grp;
		w = eff_width();
		p = eff_planes();
		psz = plane_len();
		groups = (w + GROUP_ROUND) / GROUP_PIXELS;
		h = (model_cfg.height == 0) ? 1 : model_cfg.height;
		last = (int'(row_number) + 1) >= h;
		for (int g = 0; g < groups; g++) begin
			grp = '{default: '0};
			for (int i = 0; i < GROUP_PIXELS; i++) begin
				x = g * GROUP_PIXELS + i;
				if (x < w) begin
					pix = '0;
					for (int n = 0; n < p; n++)
						pix[n] = row_mem[n * psz + (x >> 3)][7 - (x & 7)];
					grp.pixels[8 * i +: 8] = pix;
					grp.count++;
				end
			end
			grp.row_last = (g + 1 == groups);
			grp.image_last = grp.row_last && last;
			pending.insert(pending.size(), grp);
		end
		row_number = last ? '0 : row_number + 16'd1;
		rows_emitted++;
	endfunction

	// returns 0 when the byte is skipped or dropped
	function automatic bit decode_byte(logic [7:0] b);
		int unsigned rl;
		bit done, used;
		rl = row_len();
		done = 1'b0;
		used = 1'b1;
		if (!model_cfg.rle) begin
			pk = PK_HEADER;
			run_left = '0;
			if (fill_pos >= rl) fill_pos = 0;
			done = store_run(b, 1, rl);
		end else if (pk == PK_LITERAL) begin
			used = fill_pos < rl;
			done = store_run(b, 1, rl);
			run_left = run_left - 8'd1;
			if (run_left == 0) pk = PK_HEADER;
		end else if (pk == PK_REPEAT) begin
			used = fill_pos < rl;
			done = store_run(b, run_left, rl);
			run_left = '0;
			pk = PK_HEADER;
		end else begin
			if (fill_pos >= rl) fill_pos = 0;
			if (b < HDR_SKIP) begin
				pk = PK_LITERAL;
				run_left = b + 8'd1;
			end else if (b != HDR_SKIP) begin
				pk = PK_REPEAT;
				run_left = 8'(257 - int'(b));
			end else begin
				pk = PK_HEADER;
				used = 1'b0;
			end
		end
		if (done) emit_row();
		return used;
	endfunction

	function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : group_check
		pix_group_t want;
		if (arst_n && group_valid && !group_stall) begin
			if (pending.size() == 0) begin
				$display("%0t: unexpected pixel group, expected none, got %h", $time,
					pixel_group);
				mismatches++;
			end else begin
				want = pending.pop_front();
				check_field("pixel_group", want.pixels, pixel_group);
				check_field("valid_pixels", want.count, valid_pixels);
				check_field("row_end", want.row_last, row_end);
				check_field("image_end", want.image_last, image_end);
				groups_checked++;
			end
		end
	end

	always @(negedge clk)
		group_stall = arst_n && !quiet && ($urandom_range(99) < 27);

	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 27) begin
			byte_valid = 1'b0;
			@(negedge clk);
		end
		byte_valid = 1'b1;
		data_byte = b;
		do @(posedge clk); while (byte_stall);
		if (decode_byte(b)) used_bytes++;
		bytes_sent++;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_WIDTH:  model_cfg.width = val[9:0];
			REG_HEIGHT: model_cfg.height = val;
			REG_PLANES: model_cfg.planes = val[3:0];
			REG_RLE:    model_cfg.rle = val[0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic configure(input logic [15:0] w, h, p, r);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_PLANES, p);
		write_reg(REG_RLE, r);
	endtask

	// hold off until every group is out and queued run work has drained
	task automatic settle();
		@(negedge clk);
		byte_valid = 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_data();
		case ($urandom_range(4))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_packet();
		int unsigned len;
		if (!model_cfg.rle) begin
			send_byte(rand_data());
		end else begin
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5, 6, 7, 8: begin
					len = ($urandom_range(9) == 0) ? $urandom_range(1, 128) :
						$urandom_range(1, 6);
					send_byte(8'(len - 1));
					repeat (len) send_byte(rand_data());
				end
				9, 10, 11, 12, 13, 14, 15, 16: begin
					len = ($urandom_range(4) == 0) ? $urandom_range(2, 128) :
						$urandom_range(2, 12);
					send_byte(8'(257 - len));
					send_byte(rand_data());
				end
				17: send_byte(HDR_SKIP);
				default: send_byte(8'($urandom_range(255)));
			endcase
		end
	endtask

	task automatic random_config();
		logic [15:0] w, h, p;
		case ($urandom_range(19))
			0: w = 0;
			1: w = 1;
			2: w = MAX_WIDTH;
			3: w = $urandom_range(MAX_WIDTH + 1, 1023);
			4, 5: w = $urandom_range(41, MAX_WIDTH);
			default: w = $urandom_range(1, 40);
		endcase
		case ($urandom_range(9))
			0: h = 0;
			1: h = 16'hFFFF;
			2: h = $urandom_range(5, 65535);
			default: h = $urandom_range(1, 4);
		endcase
		case ($urandom_range(9))
			0: p = 0;
			1: p = $urandom_range(MAX_PLANES + 1, 15);
			default: p = $urandom_range(1, MAX_PLANES);
		endcase
		configure(w, h, p, ($urandom_range(6) != 0));
	endtask

	// reset geometry: 320 pixels, 8 planes, one row from three runs
	task automatic test_reset_defaults();
		send_byte(8'h81);
		send_byte(8'hA5);
		send_byte(8'h81);
		send_byte(8'h3C);
		send_byte(8'hC1);
		send_byte(8'hFF);
	endtask

	task automatic test_packet_kinds();
		settle();
		configure(9, 2, 2, 1);
		send_byte(HDR_SKIP);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h01);
		// run longer than the row: excess copies drop
		send_byte(8'h81);
		send_byte(8'h55);
	endtask

	task automatic test_register_extremes();
		settle();
		configure(0, 0, 0, 0);
		send_byte(8'hFF);
		send_byte(8'h00);
	endtask

	task automatic test_midrow_change();
		settle();
		configure(MAX_WIDTH, 3, 1, 1);
		send_byte(8'h05);
		send_byte(8'h11);
		send_byte(8'h22);
		send_byte(8'h33);
		settle();
		write_reg(REG_WIDTH, 16);
		send_byte(8'h44);
		send_byte(8'h55);
		send_byte(8'h66);
		send_byte(8'hFF);
		send_byte(8'h99);
		send_byte(8'h03);
		send_byte(8'h12);
		settle();
		// raw mode abandons the open literal
		write_reg(REG_RLE, 0);
		send_byte(8'h34);
	endtask

	task automatic test_random_streams();
		int target, phase, budget, start;
		target = used_bytes + RANDOM_BYTES;
		phase = 0;
		while (used_bytes < target) begin
			settle();
			random_config();
			quiet = (phase == 2);
			budget = quiet ? 80 : $urandom_range(20, 70);
			start = used_bytes;
			while (used_bytes - start < budget) send_packet();
			phase++;
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		byte_valid = 1'b0;
		data_byte = '0;
		quiet = 1'b0;
		model_cfg = '{width: RST_WIDTH, height: RST_HEIGHT, planes: RST_PLANES, rle: RST_RLE};
		pk = PK_HEADER;
		run_left = '0;
		fill_pos = 0;
		row_number = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_packet_kinds();
		test_register_extremes();
		test_midrow_change();
		test_random_streams();

		@(negedge clk);
		byte_valid = 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d body bytes (%0d decoded), %0d rows, %0d pixel groups, %0d reg writes",
			bytes_sent, used_bytes, rows_emitted, groups_checked, reg_writes);
		if (mismatches == 0 && pending.size() == 0)
			$display("[ilbm_packbits_planar_row_decoder] OK");
		else
			$display("[ilbm_packbits_planar_row_decoder] ERROR");
		$finish;
	end

endmodule
